// ===== hdl/cti_pkg.sv =====
// ============================================================================
// cti_pkg
// Shared types, constants and helpers for the character-to-integer parser.
// ============================================================================
package cti_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int OUT_BITS           = 32;
   localparam int RADIX_BITS         = 5;
   localparam int CH_BITS            = 8;
   localparam int DIGIT_BITS         = 6;

   // Radix codes.
   localparam logic [RADIX_BITS-1:0] RADIX_AUTO = 5'd0;
   localparam logic [RADIX_BITS-1:0] RADIX_BIN  = 5'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_OCT  = 5'd8;
   localparam logic [RADIX_BITS-1:0] RADIX_DEC  = 5'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_HEX  = 5'd16;

   // Status codes.
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_BAD_RADIX = 1'b1;

   // Characters of interest.
   localparam logic [CH_BITS-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CH_BITS-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CH_BITS-1:0] CHAR_HIGH  = 8'h80;
   localparam logic [CH_BITS-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CH_BITS-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CH_BITS-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CH_BITS-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CH_BITS-1:0] CHAR_UA    = 8'h41;
   localparam logic [CH_BITS-1:0] CHAR_UZ    = 8'h5A;
   localparam logic [CH_BITS-1:0] CHAR_LA    = 8'h61;
   localparam logic [CH_BITS-1:0] CHAR_LZ    = 8'h7A;
   localparam logic [CH_BITS-1:0] CHAR_LB    = 8'h62;
   localparam logic [CH_BITS-1:0] CHAR_LO    = 8'h6F;
   localparam logic [CH_BITS-1:0] CHAR_LX    = 8'h78;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_SPACE  = 5'b00010,
      PH_PREFIX = 5'b00100,
      PH_ZERO   = 5'b01000,
      PH_DIGITS = 5'b10000
   } phase_type;

   typedef struct packed {
      phase_type             phase;
      logic                  neg;
      logic [RADIX_BITS-1:0] rad;
   } cti_ctl_type;

   typedef struct packed {
      logic                  valid;
      logic [DIGIT_BITS-1:0] value;
   } digit_type;

   // Digit value of a character: 0-9, then a-z and A-Z as 10..35.
   function automatic digit_type digit_of(input logic [CH_BITS-1:0] c);
      digit_type d;
      d.valid = 1'b1;
      d.value = '0;
      if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
         d.value = DIGIT_BITS'(c - CHAR_ZERO);
      end else if (c inside {[CHAR_LA:CHAR_LZ]}) begin
         d.value = DIGIT_BITS'(c - CHAR_LA) + DIGIT_BITS'(10);
      end else if (c inside {[CHAR_UA:CHAR_UZ]}) begin
         d.value = DIGIT_BITS'(c - CHAR_UA) + DIGIT_BITS'(10);
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

   function automatic logic radix_ok(input logic [RADIX_BITS-1:0] r);
      return r inside {RADIX_AUTO, RADIX_BIN, RADIX_OCT, RADIX_DEC, RADIX_HEX};
   endfunction

endpackage

// ===== hdl/cti_step.sv =====
// ============================================================================
// cti_step
// Next-state logic for one byte: whitespace, sign, prefix and digit scan.
// ============================================================================
module cti_step
   import cti_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic [CH_BITS-1:0]    step_ch,
   input  logic                  step_first,
   input  logic [RADIX_BITS-1:0] cfg_radix,
   input  cti_ctl_type           ctl_cur,
   input  logic [VALUE_BITS-1:0] acc_cur,
   output cti_ctl_type           ctl_nxt,
   output logic [VALUE_BITS-1:0] acc_nxt,
   output logic                  emit,
   output logic                  status,
   output logic [OUT_BITS-1:0]   value
);

   phase_type             ph;
   logic                  neg;
   logic [RADIX_BITS-1:0] rad;
   logic [VALUE_BITS-1:0] acc;
   logic [VALUE_BITS-1:0] scaled;
   logic [VALUE_BITS-1:0] signed_acc;
   logic                  done;
   digit_type             dig;

   always_comb begin
      ph         = ctl_cur.phase;
      neg        = ctl_cur.neg;
      rad        = ctl_cur.rad;
      acc        = acc_cur;
      done       = 1'b0;
      emit       = 1'b0;
      status     = STATUS_OK;
      value      = '0;
      scaled     = '0;
      signed_acc = '0;
      dig        = digit_of(step_ch);

      if (step_first) begin
         acc = '0;
         neg = 1'b0;
         rad = cfg_radix;
         if (!radix_ok(cfg_radix)) begin
            ph     = PH_IDLE;
            emit   = 1'b1;
            status = STATUS_BAD_RADIX;
            done   = 1'b1;
         end else begin
            ph = PH_SPACE;
            // A NUL is skipped only as the first byte of a string.
            if (step_ch == CHAR_NUL) begin
               done = 1'b1;
            end
         end
      end

      if (!done && ph == PH_IDLE) begin
         done = 1'b1;
      end

      if (!done && ph == PH_SPACE) begin
         if (step_ch != CHAR_NUL && (step_ch <= CHAR_SPACE || step_ch >= CHAR_HIGH)) begin
            done = 1'b1;
         end else if (step_ch inside {CHAR_PLUS, CHAR_MINUS}) begin
            neg  = (step_ch == CHAR_MINUS);
            ph   = PH_PREFIX;
            done = 1'b1;
         end else begin
            ph = PH_PREFIX;
         end
      end

      if (!done && ph == PH_PREFIX) begin
         if (rad == RADIX_AUTO) begin
            rad = RADIX_DEC;
            if (step_ch == CHAR_ZERO) begin
               acc  = '0;
               ph   = PH_ZERO;
               done = 1'b1;
            end
         end
         if (!done) begin
            ph = PH_DIGITS;
         end
      end

      if (!done && ph == PH_ZERO) begin
         ph = PH_DIGITS;
         case (step_ch)
            CHAR_LX: begin
               rad  = RADIX_HEX;
               done = 1'b1;
            end
            CHAR_LB: begin
               rad  = RADIX_BIN;
               done = 1'b1;
            end
            CHAR_LO: begin
               rad  = RADIX_OCT;
               done = 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (!done && ph == PH_DIGITS) begin
         if (dig.valid && dig.value < {1'b0, rad}) begin
            // The base is always a power of two or ten here.
            case (rad)
               RADIX_BIN: scaled = acc << 1;
               RADIX_OCT: scaled = acc << 3;
               RADIX_HEX: scaled = acc << 4;
               default:   scaled = (acc << 3) + (acc << 1);
            endcase
            acc = scaled + VALUE_BITS'(dig.value);
         end else begin
            signed_acc = neg ? (~acc + VALUE_BITS'(1)) : acc;
            value      = OUT_BITS'(signed_acc);
            emit       = 1'b1;
            ph         = PH_IDLE;
         end
      end

      ctl_nxt.phase = ph;
      ctl_nxt.neg   = neg;
      ctl_nxt.rad   = rad;
      acc_nxt       = acc;
   end

endmodule

// ===== hdl/char_to_integer_parser.sv =====
// ============================================================================
// char_to_integer_parser
// Streaming ASCII-to-integer converter, one byte per transfer, one result
// per string.
// ============================================================================
// The byte that ends the number passes through the input register, then the
// result register, before its result appears.
// Throughput: one byte per cycle, limited only by the result register draining.
// Reset: synchronous; scan state idle, accumulator and radix register zero.
module char_to_integer_parser
   import cti_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CH_BITS-1:0]    req_ch,
   input  logic                  req_first,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [OUT_BITS-1:0]   rsp_value,
   output logic                  rsp_status,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [RADIX_BITS-1:0] csr_radix
);

   logic                  s1_valid_ff, s1_valid_in;
   logic [CH_BITS-1:0]    s1_ch_ff;
   logic                  s1_first_ff;
   cti_ctl_type           ctl_ff, ctl_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [RADIX_BITS-1:0] radix_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]   rsp_value_ff;
   logic                  rsp_status_ff;

   logic                  advance;
   logic                  step_emit;
   logic                  step_status;
   logic [OUT_BITS-1:0]   step_value;

   // The held byte is processed once the result register can take a result.
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || advance;
   assign s1_valid_in  = req_valid && req_ready ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? step_emit : (rsp_valid_ff && !rsp_ready);
   assign csr_ready    = 1'b1;

   cti_step #(
      .VALUE_BITS(VALUE_BITS)
   ) u_step (
      .step_ch   (s1_ch_ff),
      .step_first(s1_first_ff),
      .cfg_radix (radix_ff),
      .ctl_cur   (ctl_ff),
      .acc_cur   (acc_ff),
      .ctl_nxt   (ctl_in),
      .acc_nxt   (acc_in),
      .emit      (step_emit),
      .status    (step_status),
      .value     (step_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctl_ff.phase <= PH_IDLE;
         ctl_ff.neg   <= 1'b0;
         ctl_ff.rad   <= RADIX_AUTO;
         acc_ff       <= '0;
         radix_ff     <= RADIX_AUTO;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            ctl_ff <= ctl_in;
            acc_ff <= acc_in;
         end
         if (csr_valid && csr_ready) begin
            radix_ff <= csr_radix;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_ch_ff    <= req_ch;
         s1_first_ff <= req_first;
      end
      if (advance && step_emit) begin
         rsp_value_ff  <= step_value;
         rsp_status_ff <= step_status;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   // An invalid radix always reports a zero value.
   a_bad_radix_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_BAD_RADIX) |-> (rsp_value_ff == '0))
      else $error("invalid-radix result carries a nonzero value");

   // Digits are only scanned with a resolved, supported base.
   a_digit_radix: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff.phase == PH_DIGITS) |-> (ctl_ff.rad == RADIX_BIN || ctl_ff.rad == RADIX_OCT
                                       || ctl_ff.rad == RADIX_DEC || ctl_ff.rad == RADIX_HEX))
      else $error("digit scan with unsupported radix");

   // After a leading zero in detect mode the base is provisionally decimal.
   a_zero_radix: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff.phase == PH_ZERO) |-> (ctl_ff.rad == RADIX_DEC))
      else $error("prefix check without decimal default");

   // Emitting a result always ends the string.
   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && step_emit) |=> (ctl_ff.phase == PH_IDLE && rsp_valid_ff))
      else $error("scan not idle after a result");

endmodule
